// ----- src/bic_pkg.sv -----
// ----------------------------------------------------------------------------
// bic_pkg
// Shared types, sizes, instruction codes and the tape size table of the
// Brainfuck interpreter core.
// ----------------------------------------------------------------------------
package bic_pkg;

	// Store sizes
	localparam int PROG_DEPTH = 4096;
	localparam int PROG_AW    = $clog2(PROG_DEPTH);
	localparam int PLEN_W     = PROG_AW + 1;
	localparam int TAPE_DEPTH = 1024;
	localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
	localparam int CELL_WIDTH = 8;

	// Run status codes
	typedef enum logic [2:0] {
		ST_RUN   = 3'd0,
		ST_HALT  = 3'd1,
		ST_UNDER = 3'd2,
		ST_OVER  = 3'd3,
		ST_OPEN  = 3'd4,
		ST_CLOSE = 3'd5,
		ST_BAD   = 3'd6
	} status_t;

	// Request actions
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_EXEC  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_TAPE_SIZE = 2'd0;
	localparam logic [1:0] CFG_MIDDLE    = 2'd1;
	localparam logic [1:0] CFG_PROG_LEN  = 2'd2;

	// Instruction characters
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	// Tape length for a size select
	function automatic logic [TAPE_AW-1:0] tape_len(input logic [1:0] sel);
		logic [TAPE_AW-1:0] n;
		case (sel)
			2'd0: n = TAPE_AW'(30);
			2'd1: n = TAPE_AW'(100);
			2'd2: n = TAPE_AW'(300);
			default: n = TAPE_AW'(1000);
		endcase
		return n;
	endfunction

	// Start cell in the tape middle: length / 2 - 1
	function automatic logic [TAPE_AW-1:0] tape_mid(input logic [1:0] sel);
		logic [TAPE_AW-1:0] n;
		n = tape_len(sel);
		return TAPE_AW'((n >> 1) - TAPE_AW'(1));
	endfunction

endpackage

// ----- src/bic_ram.sv -----
// ----------------------------------------------------------------------------
// bic_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/brainfuck_interpreter_core_top.sv -----
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core_top
// Brainfuck interpreter core: program store, tape memory and a one-request
// execution sequencer.
// ----------------------------------------------------------------------------
// One request is worked on at a time and gives one result. A program write,
// an idle request or an execute while not running gives its result at the
// accepting edge. An execute first reads the program byte and the tape cell
// from their memories, then modifies the cell and writes it back where the
// instruction changes it. A taken bracket jump scans the program store one
// byte a cycle. After reset and after every start request the tape memory
// is cleared by a pass over all 1024 cells, one cell a cycle, during which
// no request is accepted; the result of a start is shown at once.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [12:0]                 cfg_data,
	// Request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  action,
	input  logic [bic_pkg::PROG_AW-1:0] prog_address,
	input  logic [7:0]                  prog_byte,
	input  logic [7:0]                  input_byte,
	// Result channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        out_valid,
	output logic [7:0]                  out_byte,
	output logic                        input_taken,
	output bic_pkg::status_t            status,
	output logic [bic_pkg::PLEN_W-1:0]  program_counter
);

	import bic_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCAN
	} state_t;

	state_t                state_q;
	logic [1:0]            tsel_q;
	logic                  mid_q;
	logic [PLEN_W-1:0]     plen_q;
	logic [TAPE_AW-1:0]    dp_q;
	logic [PLEN_W-1:0]     idx_q;
	status_t               run_q;
	logic [TAPE_AW-1:0]    clr_addr_q;
	logic [7:0]            inbyte_q;
	logic                  scan_fwd_q;
	logic [PLEN_W-1:0]     scan_addr_q;
	logic [PLEN_W-1:0]     depth_q;
	logic                  rd_vld_s1;
	logic [PLEN_W-1:0]     rd_addr_s1;

	logic                  rsp_valid_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  taken_q;
	status_t               status_q;
	logic [PLEN_W-1:0]     pc_q;

	logic                  req_acc;
	logic                  rsp_take;
	logic                  exec_go;
	logic [PLEN_W-1:0]     len;
	logic [PLEN_W-1:0]     idx_inc;

	logic [7:0]            prog_rd;
	logic                  prog_re;
	logic [PROG_AW-1:0]    prog_raddr;
	logic [CELL_WIDTH-1:0] cell_rd;
	logic                  tape_we;
	logic [TAPE_AW-1:0]    tape_waddr;
	logic [CELL_WIDTH-1:0] tape_wdata;

	// Execute stage decisions
	logic                  ex_write;
	logic [CELL_WIDTH-1:0] ex_cell;
	logic [TAPE_AW-1:0]    ex_dp;
	logic [PLEN_W-1:0]     ex_idx;
	status_t               ex_status;
	logic                  ex_out;
	logic                  ex_taken;
	logic                  ex_scan;
	logic                  ex_fwd;

	// Scan stage decisions
	logic                  scan_more;
	logic                  scan_issue;
	logic                  scan_hit;
	logic                  scan_miss;
	logic [PLEN_W-1:0]     scan_next;
	logic [PLEN_W-1:0]     hit_idx;

	assign cfg_ready = 1'b1;
	assign len       = (plen_q > PLEN_W'(PROG_DEPTH)) ? PLEN_W'(PROG_DEPTH) : plen_q;
	assign idx_inc   = PLEN_W'(idx_q + PLEN_W'(1));

	// Handshakes: one request in flight, result register must not be stalled
	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign exec_go   = req_acc && (action == ACT_EXEC) && (run_q == ST_RUN) && (idx_q < len);

	// Scan address sequencing
	always_comb begin
		scan_hit  = 1'b0;
		if (rd_vld_s1) begin
			if (scan_fwd_q) begin
				scan_hit = (prog_rd == CH_CLOSE) && (depth_q == PLEN_W'(1));
			end else begin
				scan_hit = (prog_rd == CH_OPEN) && (depth_q == PLEN_W'(1));
			end
		end
		scan_more  = scan_fwd_q ? (scan_addr_q < len) : (scan_addr_q != '0);
		scan_issue = (state_q == S_SCAN) && !scan_hit && scan_more;
		scan_miss  = (state_q == S_SCAN) && !rd_vld_s1 && !scan_more;
		scan_next  = scan_fwd_q ? PLEN_W'(scan_addr_q + PLEN_W'(1))
		                        : PLEN_W'(scan_addr_q - PLEN_W'(1));
		hit_idx    = PLEN_W'(rd_addr_s1 + PLEN_W'(1));
	end

	// Program store read address
	always_comb begin
		prog_re    = exec_go || scan_issue;
		prog_raddr = idx_q[PROG_AW-1:0];
		if (state_q == S_SCAN) begin
			prog_raddr = scan_fwd_q ? scan_addr_q[PROG_AW-1:0] : scan_next[PROG_AW-1:0];
		end
	end

	// Decode one instruction on the read program byte and cell
	always_comb begin
		ex_write  = 1'b0;
		ex_cell   = cell_rd;
		ex_dp     = dp_q;
		ex_idx    = idx_inc;
		ex_status = ST_RUN;
		ex_out    = 1'b0;
		ex_taken  = 1'b0;
		ex_scan   = 1'b0;
		ex_fwd    = 1'b1;
		case (prog_rd)
			CH_LEFT: begin
				if (dp_q == '0) begin
					ex_status = ST_UNDER;
					ex_idx    = idx_q;
				end else begin
					ex_dp = TAPE_AW'(dp_q - TAPE_AW'(1));
				end
			end
			CH_RIGHT: begin
				if (dp_q >= TAPE_AW'(tape_len(tsel_q) - TAPE_AW'(1))) begin
					ex_status = ST_OVER;
					ex_idx    = idx_q;
				end else begin
					ex_dp = TAPE_AW'(dp_q + TAPE_AW'(1));
				end
			end
			CH_INC: begin
				ex_write = 1'b1;
				ex_cell  = CELL_WIDTH'(cell_rd + CELL_WIDTH'(1));
			end
			CH_DEC: begin
				ex_write = 1'b1;
				ex_cell  = CELL_WIDTH'(cell_rd - CELL_WIDTH'(1));
			end
			CH_OUT: begin
				ex_out = 1'b1;
			end
			CH_IN: begin
				ex_write = 1'b1;
				ex_taken = 1'b1;
				ex_cell  = CELL_WIDTH'(inbyte_q);
			end
			CH_OPEN: begin
				ex_scan = (cell_rd == '0);
				ex_fwd  = 1'b1;
			end
			CH_CLOSE: begin
				ex_scan = (cell_rd != '0);
				ex_fwd  = 1'b0;
			end
			default: begin
				ex_status = ST_BAD;
				ex_idx    = idx_q;
			end
		endcase
		// Halt once the counter reaches the program length
		if ((ex_status == ST_RUN) && (ex_idx >= len)) begin
			ex_status = ST_HALT;
		end
	end

	// Tape write port: clearing pass or cell write-back
	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = dp_q;
		tape_wdata = ex_cell;
		if (state_q == S_CLEAR) begin
			tape_we    = 1'b1;
			tape_waddr = clr_addr_q;
			tape_wdata = '0;
		end else if (state_q == S_EXEC) begin
			tape_we = ex_write;
		end
	end

	bic_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog_ram (
		.clk   (clk),
		.we    (req_acc && (action == ACT_WRITE)),
		.waddr (prog_address),
		.wdata (prog_byte),
		.re    (prog_re),
		.raddr (prog_raddr),
		.rdata (prog_rd)
	);

	bic_ram #(.WIDTH(CELL_WIDTH), .DEPTH(TAPE_DEPTH)) u_tape_ram (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (exec_go),
		.raddr (dp_q),
		.rdata (cell_rd)
	);

	// Sequencer, run state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			tsel_q      <= '0;
			mid_q       <= 1'b0;
			plen_q      <= '0;
			dp_q        <= '0;
			idx_q       <= '0;
			run_q       <= ST_HALT;
			clr_addr_q  <= '0;
			inbyte_q    <= '0;
			scan_fwd_q  <= 1'b1;
			scan_addr_q <= '0;
			depth_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_addr_s1  <= '0;
			rsp_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			taken_q     <= 1'b0;
			status_q    <= ST_HALT;
			pc_q        <= '0;
		end else begin
			// Configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TAPE_SIZE: tsel_q <= cfg_data[1:0];
					CFG_MIDDLE:    mid_q  <= cfg_data[0];
					CFG_PROG_LEN:  plen_q <= cfg_data[PLEN_W-1:0];
					default: ;
				endcase
			end

			// Drop a taken result
			if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= TAPE_AW'(clr_addr_q + TAPE_AW'(1));
					if (clr_addr_q == TAPE_AW'(TAPE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (req_acc) begin
						inbyte_q <= input_byte;
						if (exec_go) begin
							state_q <= S_EXEC;
						end else begin
							rsp_valid_q <= 1'b1;
							out_valid_q <= 1'b0;
							out_byte_q  <= '0;
							taken_q     <= 1'b0;
							status_q    <= run_q;
							pc_q        <= idx_q;
							if (action == ACT_START) begin
								dp_q       <= mid_q ? tape_mid(tsel_q) : '0;
								idx_q      <= '0;
								run_q      <= (len == '0) ? ST_HALT : ST_RUN;
								status_q   <= (len == '0) ? ST_HALT : ST_RUN;
								pc_q       <= '0;
								clr_addr_q <= '0;
								state_q    <= S_CLEAR;
							end else if ((action == ACT_EXEC) && (run_q == ST_RUN)) begin
								// Counter at or past the length
								run_q    <= ST_HALT;
								status_q <= ST_HALT;
							end
						end
					end
				end

				S_EXEC: begin
					if (ex_scan) begin
						scan_fwd_q  <= ex_fwd;
						scan_addr_q <= ex_fwd ? idx_inc : idx_q;
						depth_q     <= PLEN_W'(1);
						rd_vld_s1   <= 1'b0;
						state_q     <= S_SCAN;
					end else begin
						dp_q        <= ex_dp;
						idx_q       <= ex_idx;
						run_q       <= ex_status;
						rsp_valid_q <= 1'b1;
						out_valid_q <= ex_out;
						out_byte_q  <= ex_out ? cell_rd[7:0] : 8'd0;
						taken_q     <= ex_taken;
						status_q    <= ex_status;
						pc_q        <= ex_idx;
						state_q     <= S_IDLE;
					end
				end

				S_SCAN: begin
					// Advance the read address and track nesting depth
					rd_vld_s1  <= scan_issue;
					rd_addr_s1 <= scan_fwd_q ? scan_addr_q : scan_next;
					if (scan_issue) begin
						scan_addr_q <= scan_next;
					end
					if (rd_vld_s1 && !scan_hit) begin
						if ((scan_fwd_q && (prog_rd == CH_OPEN)) ||
						    (!scan_fwd_q && (prog_rd == CH_CLOSE))) begin
							depth_q <= PLEN_W'(depth_q + PLEN_W'(1));
						end else if ((scan_fwd_q && (prog_rd == CH_CLOSE)) ||
						             (!scan_fwd_q && (prog_rd == CH_OPEN))) begin
							depth_q <= PLEN_W'(depth_q - PLEN_W'(1));
						end
					end
					if (scan_hit || scan_miss) begin
						rsp_valid_q <= 1'b1;
						out_valid_q <= 1'b0;
						out_byte_q  <= '0;
						taken_q     <= 1'b0;
						rd_vld_s1   <= 1'b0;
						state_q     <= S_IDLE;
						if (scan_hit) begin
							idx_q    <= hit_idx;
							pc_q     <= hit_idx;
							run_q    <= (hit_idx >= len) ? ST_HALT : ST_RUN;
							status_q <= (hit_idx >= len) ? ST_HALT : ST_RUN;
						end else begin
							pc_q     <= idx_q;
							run_q    <= scan_fwd_q ? ST_OPEN : ST_CLOSE;
							status_q <= scan_fwd_q ? ST_OPEN : ST_CLOSE;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign input_taken     = taken_q;
	assign status          = status_q;
	assign program_counter = pc_q;

endmodule

// ----- src/bic_checker.sv -----
// ----------------------------------------------------------------------------
// bic_checker
// Port-level checks of the Brainfuck interpreter core, bound to the top level.
// ----------------------------------------------------------------------------
module bic_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_stall,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  logic                        out_valid,
	input  logic [7:0]                  out_byte,
	input  logic                        input_taken,
	input  logic [2:0]                  status,
	input  logic [bic_pkg::PLEN_W-1:0]  program_counter
);

	import bic_pkg::*;

	// A stalled result blocks new requests
	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |-> req_stall)
		else $error("request accepted while result is stalled");

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) &&
		 $stable(program_counter) && $stable(out_byte)))
		else $error("stalled result changed");

	// An output byte comes only from a successful step
	a_out_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && out_valid) |-> (!input_taken &&
		 (status == ST_RUN || status == ST_HALT)))
		else $error("output byte on a faulted or input step");

	// No output byte means a zero byte field
	a_out_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !out_valid) |-> (out_byte == 8'd0))
		else $error("output byte set without output");

	// The counter never passes the store depth
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (program_counter <= PLEN_W'(PROG_DEPTH)))
		else $error("program counter beyond store depth");

endmodule

bind brainfuck_interpreter_core_top bic_checker u_bic_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_stall       (req_stall),
	.rsp_valid       (rsp_valid),
	.rsp_stall       (rsp_stall),
	.out_valid       (out_valid),
	.out_byte        (out_byte),
	.input_taken     (input_taken),
	.status          (status),
	.program_counter (program_counter)
);
